// ----- rtl/wcsp_pkg.sv -----
// Shared types, codes and constants of the RIFF/WAVE chunk stream parser.
package wcsp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned RATE_W     = 32;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [31:0] ID_FMT       = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA      = 32'h6174_6164;
   localparam logic [31:0] FMT_LEN      = 32'd16;
   localparam logic [3:0]  FMT_LAST_IDX = 4'd15;
   localparam logic [3:0]  BITS_AT      = 4'd14;
   localparam logic [3:0]  FILE_LAST_IDX = 4'd11;
   localparam logic [3:0]  CHUNK_LAST_IDX = 4'd7;
   localparam logic [RATE_W-1:0] RATE_RESET = 32'd8000;

   // Result kinds.
   localparam logic [KIND_W-1:0] EV_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] EV_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] EV_ERROR  = 2'd2;

   // Error codes.
   localparam logic [CODE_W-1:0] ERR_NONE       = 3'd0;
   localparam logic [CODE_W-1:0] ERR_BAD_HEADER = 3'd0;
   localparam logic [CODE_W-1:0] ERR_SHORT_FMT  = 3'd1;
   localparam logic [CODE_W-1:0] ERR_NO_FMT     = 3'd2;
   localparam logic [CODE_W-1:0] ERR_UNSUPPORTED = 3'd3;
   localparam logic [CODE_W-1:0] ERR_TRUNCATED  = 3'd4;

   typedef enum logic [6:0] {
      PH_FILE  = 7'b000_0001,
      PH_CHUNK = 7'b000_0010,
      PH_FMT   = 7'b000_0100,
      PH_SKIP  = 7'b000_1000,
      PH_DATA  = 7'b001_0000,
      PH_PAD   = 7'b010_0000,
      PH_HALT  = 7'b100_0000
   } phase_type;

   // One queued input transfer.
   typedef struct packed {
      logic              eoi;
      logic [BYTE_W-1:0] data;
   } item_type;

   // One result.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] sample;
   } result_type;

   // Expected byte of the 12-byte file header; check is low for the size bytes.
   function automatic logic [BYTE_W:0] file_magic(input logic [3:0] idx);
      logic [BYTE_W:0] r;
      begin
         case (idx)
            4'd0:    r = {1'b1, 8'h52};
            4'd1:    r = {1'b1, 8'h49};
            4'd2:    r = {1'b1, 8'h46};
            4'd3:    r = {1'b1, 8'h46};
            4'd8:    r = {1'b1, 8'h57};
            4'd9:    r = {1'b1, 8'h41};
            4'd10:   r = {1'b1, 8'h56};
            4'd11:   r = {1'b1, 8'h45};
            default: r = {1'b0, 8'h00};
         endcase
         return r;
      end
   endfunction

endpackage

// ----- rtl/wcsp_queue.sv -----
// Front end: takes input transfers and holds them in a short FIFO for the parser.
module wcsp_queue
   import wcsp_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != FULL_CNT);
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/wcsp_parser.sv -----
// Back end: chunk state machine, captured format fields and the result register.
module wcsp_parser
   import wcsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_wr_en,
   input  logic [RATE_W-1:0] cfg_wr_data,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output result_type        out_result
);

   phase_type         phase_ff, phase_in;
   logic [3:0]        idx_ff, idx_in;
   logic [55:0]       hdr_ff, hdr_in;
   logic              bad_ff, bad_in;
   logic [7:0]        scr_ff, scr_in;
   logic [31:0]       rem_ff, rem_in;
   logic              pad_ff, pad_in;
   logic              seen_ff, seen_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              pcm_ff, pcm_in;
   logic              mono_ff, mono_in;
   logic              bits8_ff, bits8_in;
   logic [RATE_W-1:0] req_rate_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        res_ff, res_in;

   logic              take, emit, body_end, chunk_end;
   logic [63:0]       full_hdr;
   logic [31:0]       size, rem_dec;
   logic [15:0]       word;
   logic [8:0]        magic;

   assign in_ready   = !out_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = res_ff;

   assign full_hdr = {in_item.data, hdr_ff};
   assign size     = full_hdr[63:32];
   assign word     = {in_item.data, scr_ff};
   assign rem_dec  = rem_ff - {31'd0, (rem_ff != '0)};
   assign magic    = file_magic(idx_ff);

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      hdr_in    = hdr_ff;
      bad_in    = bad_ff;
      scr_in    = scr_ff;
      rem_in    = rem_ff;
      pad_in    = pad_ff;
      seen_in   = seen_ff;
      rate_in   = rate_ff;
      pcm_in    = pcm_ff;
      mono_in   = mono_ff;
      bits8_in  = bits8_ff;
      emit      = 1'b0;
      body_end  = 1'b0;
      chunk_end = 1'b0;
      res_in    = '{code: ERR_NONE, kind: EV_SAMPLE, sample: '0};

      if (take && (phase_ff != PH_HALT)) begin
         if (in_item.eoi) begin
            emit     = 1'b1;
            phase_in = PH_HALT;
            if (phase_ff == PH_CHUNK) begin
               res_in.kind = EV_DONE;
            end else begin
               res_in.kind = EV_ERROR;
               res_in.code = ERR_TRUNCATED;
            end
         end else begin
            unique case (phase_ff)
               PH_FILE: begin
                  if (magic[8] && (in_item.data != magic[7:0])) begin
                     bad_in = 1'b1;
                  end
                  if (idx_ff >= FILE_LAST_IDX) begin
                     if (bad_in) begin
                        emit        = 1'b1;
                        phase_in    = PH_HALT;
                        res_in.kind = EV_ERROR;
                        res_in.code = ERR_BAD_HEADER;
                     end else begin
                        phase_in = PH_CHUNK;
                        idx_in   = '0;
                     end
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               PH_CHUNK: begin
                  hdr_in = full_hdr[63:8];
                  if (idx_ff < CHUNK_LAST_IDX) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     idx_in = '0;
                     pad_in = size[0];
                     if (full_hdr[31:0] == ID_FMT) begin
                        if (size[31:4] == '0) begin
                           emit        = 1'b1;
                           phase_in    = PH_HALT;
                           res_in.kind = EV_ERROR;
                           res_in.code = ERR_SHORT_FMT;
                        end else begin
                           rem_in   = size - FMT_LEN;
                           phase_in = PH_FMT;
                        end
                     end else if (full_hdr[31:0] == ID_DATA) begin
                        if (!seen_ff) begin
                           emit        = 1'b1;
                           phase_in    = PH_HALT;
                           res_in.kind = EV_ERROR;
                           res_in.code = ERR_NO_FMT;
                        end else if (!(pcm_ff && mono_ff && bits8_ff &&
                                       (rate_ff == req_rate_ff))) begin
                           emit        = 1'b1;
                           phase_in    = PH_HALT;
                           res_in.kind = EV_ERROR;
                           res_in.code = ERR_UNSUPPORTED;
                        end else begin
                           rem_in = size;
                           if (size != '0) begin
                              phase_in = PH_DATA;
                           end else begin
                              chunk_end = 1'b1;
                           end
                        end
                     end else begin
                        rem_in   = size;
                        body_end = 1'b1;
                     end
                  end
               end
               PH_FMT: begin
                  case (idx_ff)
                     4'd0: begin
                        rate_in  = '0;
                        pcm_in   = 1'b0;
                        mono_in  = 1'b0;
                        bits8_in = 1'b0;
                        scr_in   = in_item.data;
                     end
                     4'd1: pcm_in  = (word == 16'd1);
                     4'd2: scr_in  = in_item.data;
                     4'd3: mono_in = (word == 16'd1);
                     4'd4: rate_in[7:0]   = in_item.data;
                     4'd5: rate_in[15:8]  = in_item.data;
                     4'd6: rate_in[23:16] = in_item.data;
                     4'd7: rate_in[31:24] = in_item.data;
                     BITS_AT: scr_in = in_item.data;
                     FMT_LAST_IDX: bits8_in = (word == 16'd8);
                     default: ;
                  endcase
                  if (idx_ff == FMT_LAST_IDX) begin
                     seen_in  = 1'b1;
                     idx_in   = '0;
                     body_end = 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               PH_SKIP: begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     chunk_end = 1'b1;
                  end
               end
               PH_DATA: begin
                  rem_in        = rem_dec;
                  emit          = 1'b1;
                  res_in.sample = in_item.data;
                  if (rem_dec == '0) begin
                     chunk_end = 1'b1;
                  end
               end
               PH_PAD: begin
                  pad_in    = 1'b0;
                  chunk_end = 1'b1;
               end
               PH_HALT: ;
               default: ;
            endcase

            // After a fmt body or an unknown chunk header: skip what is left.
            if (body_end) begin
               if (rem_in != '0) begin
                  phase_in = PH_SKIP;
               end else begin
                  chunk_end = 1'b1;
               end
            end
            // A chunk is finished: its pad byte, or the next chunk header.
            if (chunk_end) begin
               if (pad_in) begin
                  phase_in = PH_PAD;
               end else begin
                  phase_in = PH_CHUNK;
                  idx_in   = '0;
               end
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_ready) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FILE;
         idx_ff       <= '0;
         bad_ff       <= 1'b0;
         rem_ff       <= '0;
         pad_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         rate_ff      <= '0;
         pcm_ff       <= 1'b0;
         mono_ff      <= 1'b0;
         bits8_ff     <= 1'b0;
         req_rate_ff  <= RATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         bad_ff       <= bad_in;
         rem_ff       <= rem_in;
         pad_ff       <= pad_in;
         seen_ff      <= seen_in;
         rate_ff      <= rate_in;
         pcm_ff       <= pcm_in;
         mono_ff      <= mono_in;
         bits8_ff     <= bits8_in;
         out_valid_ff <= out_valid_in;
         if (cfg_wr_en) begin
            req_rate_ff <= cfg_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      scr_ff <= scr_in;
      if (in_ready && emit) begin
         res_ff <= res_in;
      end
   end

endmodule

// ----- rtl/wav_chunk_stream_parser.sv -----
// Top level of the RIFF/WAVE chunk stream parser: input queue and parser back end.
//
// Channel   Direction  Transfer                          Payload
// req_      in         one file byte or the end mark     tdata: file_byte; tuser: end_of_input
// rsp_      out        one sample, finish or error       tdata: sample_byte, error_code;
//                                                        tuser: event_kind
// csr_      in         write of required_sample_rate     csr_wr_data, 32 bits
//
// The block takes one input transfer per cycle when the result side keeps up.
// Each queued byte is parsed by the back end, and a result, when the byte
// causes one, is shown on rsp_ in the next cycle from an output register.
// Through an empty queue, a byte passes a queue slot and then the output register.
// Reset is synchronous and returns the parser to the file header phase with the sample
// rate register at 8000.
// A stall on rsp_ holds the back end; the queue of QUEUE_DEPTH entries keeps req_tready
// high until it fills.
module wav_chunk_stream_parser
   import wcsp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input bytes.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] file_byte
   input  logic                  req_tuser,   // [0] end_of_input
   // Results.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] sample_byte, [10:8] error_code
   output logic [KIND_W-1:0]     rsp_tuser,   // [1:0] event_kind
   // Configuration.
   input  logic                  csr_wr_en,
   input  logic [RATE_W-1:0]     csr_wr_data
);

   item_type   req_item;
   item_type   q_item;
   logic       q_valid;
   logic       q_ready;
   result_type result;

   // The end mark rides beside the byte; the byte is ignored when it is set.
   assign req_item.data = req_tdata;
   assign req_item.eoi  = req_tuser;

   wcsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   wcsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg_wr_en   (csr_wr_en),
      .cfg_wr_data (csr_wr_data),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_item     (q_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   // Pack the result: sample in the low byte, error code above it, zeros to 16 bits.
   assign rsp_tdata = {{(RSP_DATA_W - BYTE_W - CODE_W){1'b0}}, result.code, result.sample};
   assign rsp_tuser = result.kind;

endmodule

// ----- rtl/wcsp_checker.sv -----
// Port-level checks on the parser's result channel, bound to the top level.
module wcsp_checker
   import wcsp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]     rsp_tuser
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // After the finish or error transfer the parser has halted and sends nothing more.
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser != EV_SAMPLE) |=> !rsp_tvalid)
      else $error("result sent after the terminating event");

   // A finish event carries no sample and no error code.
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_DONE) |-> (rsp_tdata == '0))
      else $error("finish event with nonzero payload");

   // An error event carries a known code and no sample; a sample carries no code.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == EV_ERROR) ?
         (rsp_tdata[BYTE_W +: CODE_W] <= ERR_TRUNCATED) && (rsp_tdata[BYTE_W-1:0] == '0) :
         (rsp_tdata[BYTE_W +: CODE_W] == ERR_NONE)))
      else $error("bad error code or stray payload");

   // Nothing is shown right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind wav_chunk_stream_parser wcsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_wav_chunk_stream_parser.sv -----
// Self-checking testbench for the RIFF/WAVE chunk stream parser.
`timescale 1ns / 100ps

module tb_wav_chunk_stream_parser;
   import wcsp_pkg::*;

   // Cycles allowed after the last expected result for anything still in flight.
   // This covers the output register plus the input queue.
   localparam int DRAIN_CYCLES = 8;
   // Length of the long receiver hold-off that fills the input queue.
   localparam int HOLD_CYCLES  = 64;
   // The run fails when this many cycles pass without any transfer.
   localparam int IDLE_LIMIT   = 2000;

   // The 12 bytes of the file header, first byte in the top bits.
   // The four size bytes in the middle are never compared.
   localparam logic [95:0] FILE_SIG = 96'h5249_4646_0000_0000_5741_5645;
   localparam logic [31:0] ID_LIST  = 32'h5453_494C;   // "LIST", an ordinary skipped chunk
   localparam logic [15:0] TAG_PCM  = 16'd1;
   localparam logic [15:0] MONO     = 16'd1;
   localparam logic [15:0] BITS_8   = 16'd8;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_wr_en;
   logic [RATE_W-1:0]     csr_wr_data;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   wav_chunk_stream_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Parser mirror. This is the testbench's own copy of the parse state,
   // stepped once for every accepted input transfer.
   // ------------------------------------------------------------------
   phase_type         p_phase  = PH_FILE;
   logic [3:0]        p_idx    = '0;
   logic [63:0]       p_hdr    = '0;   // mismatch flag, header bytes or scratch byte
   logic [31:0]       p_left   = '0;
   logic              p_pad    = 1'b0;
   logic              p_seen   = 1'b0;
   logic [63:0]       p_fields = '0;   // rate, then PCM, mono and 8-bit flags
   logic [RATE_W-1:0] p_rate   = RATE_RESET;

   // Results still owed by the block, oldest first.
   result_type pending_events[$];

   // What the stimulus knows about the last fmt chunk it sent.
   bit          fmt_good = 1'b0;
   logic [31:0] fmt_rate = '0;

   bit no_gaps  = 1'b0;   // set for stretches in which the sender never idles
   bit hold_rsp = 1'b0;   // asks the receiver for one long hold-off

   int fail_count     = 0;
   int items_sent     = 0;
   int chunks_sent    = 0;
   int rate_writes    = 0;
   int samples_seen   = 0;
   int last_kind      = -1;
   int last_code      = -1;

   task automatic post_event(input logic [7:0] sample, input logic [KIND_W-1:0] kind,
                             input logic [CODE_W-1:0] code);
      result_type r;
      r.sample = sample;
      r.kind   = kind;
      r.code   = code;
      pending_events.push_back(r);
   endtask

   // A chunk is over: either its pad byte follows or the next header starts.
   task automatic close_chunk();
      if (p_pad) begin
         p_phase = PH_PAD;
      end else begin
         p_phase = PH_CHUNK;
         p_idx   = '0;
         p_hdr   = '0;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eoi);
      logic [31:0] id;
      logic [31:0] size;
      logic [15:0] word;
      logic [3:0]  i;
      i = p_idx;
      if (p_phase == PH_HALT) begin
         return;
      end
      // The end mark finishes cleanly only between chunks or inside a chunk header.
      if (eoi) begin
         if (p_phase == PH_CHUNK) begin
            post_event(8'd0, EV_DONE, ERR_NONE);
         end else begin
            post_event(8'd0, EV_ERROR, ERR_TRUNCATED);
         end
         p_phase = PH_HALT;
         return;
      end
      case (p_phase)
         PH_FILE: begin
            if ((i < 4 || (i >= 8 && i < 12)) && b != FILE_SIG[95 - 8*i -: 8]) begin
               p_hdr = 64'd1;
            end
            // A bad file header is only reported once all twelve bytes are in.
            if (i >= 11) begin
               if (p_hdr != 0) begin
                  post_event(8'd0, EV_ERROR, ERR_BAD_HEADER);
                  p_phase = PH_HALT;
               end else begin
                  p_phase = PH_CHUNK;
                  p_idx   = '0;
                  p_hdr   = '0;
               end
            end else begin
               p_idx = i + 4'd1;
            end
         end
         PH_CHUNK: begin
            p_hdr = {b, p_hdr[63:8]};
            if (i < 7) begin
               p_idx = i + 4'd1;
            end else begin
               id    = p_hdr[31:0];
               size  = p_hdr[63:32];
               p_idx = '0;
               p_pad = size[0];
               if (id == ID_FMT) begin
                  if (size < FMT_LEN) begin
                     post_event(8'd0, EV_ERROR, ERR_SHORT_FMT);
                     p_phase = PH_HALT;
                  end else begin
                     p_left  = size - FMT_LEN;
                     p_phase = PH_FMT;
                  end
               end else if (id == ID_DATA) begin
                  // The rate is compared with the register as it stands right now.
                  if (!p_seen) begin
                     post_event(8'd0, EV_ERROR, ERR_NO_FMT);
                     p_phase = PH_HALT;
                  end else if (p_fields[34:32] != 3'b111 || p_fields[31:0] != p_rate) begin
                     post_event(8'd0, EV_ERROR, ERR_UNSUPPORTED);
                     p_phase = PH_HALT;
                  end else begin
                     p_left = size;
                     if (size != 0) begin
                        p_phase = PH_DATA;
                     end else begin
                        close_chunk();
                     end
                  end
               end else begin
                  p_left = size;
                  if (size != 0) begin
                     p_phase = PH_SKIP;
                  end else begin
                     close_chunk();
                  end
               end
            end
         end
         PH_FMT: begin
            word = {b, p_hdr[7:0]};
            if (i == 0) begin
               p_fields = '0;
               p_hdr    = {56'd0, b};
            end else if (i == 1) begin
               if (word == 16'd1) begin
                  p_fields[32] = 1'b1;
               end
            end else if (i == 2) begin
               p_hdr = {56'd0, b};
            end else if (i == 3) begin
               if (word == 16'd1) begin
                  p_fields[33] = 1'b1;
               end
            end else if (i >= 4 && i < 8) begin
               p_fields = p_fields | ({56'd0, b} << (8 * (i - 4)));
            end else if (i == BITS_AT) begin
               p_hdr = {56'd0, b};
            end else if (i == BITS_AT + 4'd1) begin
               if (word == 16'd8) begin
                  p_fields[34] = 1'b1;
               end
            end
            if (i >= FMT_LAST_IDX) begin
               p_seen = 1'b1;
               p_idx  = '0;
               if (p_left != 0) begin
                  p_phase = PH_SKIP;
               end else begin
                  close_chunk();
               end
            end else begin
               p_idx = i + 4'd1;
            end
         end
         PH_SKIP: begin
            if (p_left != 0) begin
               p_left = p_left - 32'd1;
            end
            if (p_left == 0) begin
               close_chunk();
            end
         end
         PH_DATA: begin
            if (p_left != 0) begin
               p_left = p_left - 32'd1;
            end
            if (p_left == 0) begin
               close_chunk();
            end
            post_event(b, EV_SAMPLE, ERR_NONE);
         end
         PH_PAD: begin
            p_pad = 1'b0;
            close_chunk();
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Result checking and input tracking. DUT outputs are read right after
   // the rising edge, so they still hold the values the edge sampled.
   // ------------------------------------------------------------------
   result_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected result transfer: event_kind %0d, sample_byte %0h",
                      rsp_tuser, rsp_tdata[7:0]);
               fail_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_tdata[7:0] !== want.sample) begin
                  $error("sample_byte: expected %0h, got %0h", want.sample, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.kind) begin
                  $error("event_kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[10:8] !== want.code) begin
                  $error("error_code: expected %0d, got %0d", want.code, rsp_tdata[10:8]);
                  fail_count++;
               end
               if (want.kind == EV_SAMPLE) begin
                  samples_seen++;
               end else begin
                  last_kind = int'(want.kind);
                  last_code = int'(want.code);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser);
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver. It may stall before each result, has stretches
   // with no stalls at all, and takes one long hold-off when asked.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      forever begin
         if (taken % 24 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         stall = steady ? 0 : $urandom_range(0, 3);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Ends the run if the block stops moving data in either direction.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender helpers.
   // ------------------------------------------------------------------

   // Offers one input transfer after a random gap and waits until it is taken.
   // Valid stays high between back-to-back transfers.
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Sends the low bytes of a value, least significant first.
   task automatic send_le(input logic [31:0] v, input int nbytes);
      for (int k = 0; k < nbytes; k++) begin
         send_byte(v[8*k +: 8], 1'b0);
      end
   endtask

   task automatic send_chunk_header(input logic [31:0] id, input logic [31:0] size);
      send_le(id, 4);
      send_le(size, 4);
      chunks_sent++;
   endtask

   // A fmt chunk with the given fields, random byte rate and block align,
   // and extra trailing bytes that the block must skip.
   task automatic send_fmt_chunk(input logic [15:0] tag, input logic [15:0] chans,
                                 input logic [15:0] bits, input logic [31:0] rate,
                                 input int extra);
      logic [31:0] size;
      size = 32'd16 + extra;
      send_chunk_header(ID_FMT, size);
      send_le(32'(tag), 2);
      send_le(32'(chans), 2);
      send_le(rate, 4);
      send_le($urandom, 4);
      send_le($urandom, 2);
      send_le(32'(bits), 2);
      repeat (extra) send_byte(8'($urandom), 1'b0);
      if (size[0]) begin
         send_byte(8'($urandom), 1'b0);
      end
      fmt_good = (tag == TAG_PCM && chans == MONO && bits == BITS_8);
      fmt_rate = rate;
   endtask

   // Any chunk with a body of random bytes and its pad byte where the size is odd.
   task automatic send_body_chunk(input logic [31:0] id, input int n);
      send_chunk_header(id, n);
      repeat (n) send_byte(8'($urandom), 1'b0);
      if (n % 2 == 1) begin
         send_byte(8'($urandom), 1'b0);
      end
   endtask

   // Writes the rate register once the block has nothing left in flight.
   task automatic write_rate(input logic [31:0] v);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      p_rate = v;
      rate_writes++;
   endtask

   function automatic bit format_accepted();
      return fmt_good && fmt_rate == p_rate;
   endfunction

   // ------------------------------------------------------------------
   // Tests. The block halts for good after its first finish or error event,
   // and reset is applied only once, so the whole run is one long file and
   // the stream is ended only in the last test.
   // ------------------------------------------------------------------

   // RIFF, a size field with both byte extremes, then WAVE.
   task automatic test_file_header();
      send_le(32'h4646_4952, 4);
      send_le(32'hFF00_00FF, 4);
      send_le(32'h4556_4157, 4);
   endtask

   // The first fmt chunk declares the rate the register holds after reset.
   task automatic test_first_format();
      send_fmt_chunk(TAG_PCM, MONO, BITS_8, RATE_RESET, 0);
   endtask

   // Sample byte extremes in an odd-sized data chunk, an empty data chunk,
   // and skipped chunks including one whose id is one bit away from fmt.
   task automatic test_sample_extremes();
      send_chunk_header(ID_DATA, 32'd5);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_body_chunk(ID_DATA, 0);
      send_body_chunk(ID_FMT ^ 32'd1, 3);
      send_body_chunk(ID_LIST, 0);
   endtask

   // Rate register at both extremes, and a check that the rate is compared
   // when the data header ends rather than when the fmt chunk arrives.
   task automatic test_rate_register();
      write_rate(32'd0);
      send_fmt_chunk(TAG_PCM, MONO, BITS_8, 32'd0, 0);
      send_body_chunk(ID_DATA, 2);
      write_rate(32'hFFFF_FFFF);
      send_fmt_chunk(TAG_PCM, MONO, BITS_8, 32'hFFFF_FFFF, 2);
      send_body_chunk(ID_DATA, 3);
      send_fmt_chunk(TAG_PCM, MONO, BITS_8, 32'd44100, 1);
      write_rate(32'd44100);
      send_body_chunk(ID_DATA, 4);
   endtask

   // A second fmt chunk replaces the fields of an unusable first one.
   task automatic test_format_replaced();
      send_fmt_chunk(TAG_PCM, 16'd2, BITS_8, p_rate, 0);
      send_fmt_chunk(TAG_PCM, MONO, BITS_8, p_rate, 0);
      send_body_chunk(ID_DATA, 1);
   endtask

   // The receiver holds off while a long data chunk keeps coming, so the
   // input queue fills and the block must stall its input side.
   task automatic test_input_backpressure();
      hold_rsp = 1'b1;
      no_gaps  = 1'b1;
      send_body_chunk(ID_DATA, 48);
      no_gaps  = 1'b0;
   endtask

   // Mostly well-formed chunk sequences with random content, mixed with
   // unusable fmt chunks, unknown chunks and rate changes between chunks.
   task automatic test_random_chunks();
      int start;
      int pick;
      int n;
      logic [31:0] id;
      logic [31:0] rate;
      logic [15:0] tag;
      logic [15:0] chans;
      logic [15:0] bits;
      start = items_sent;
      while (items_sent - start < 220) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 45) begin
            if (format_accepted()) begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
               send_body_chunk(ID_DATA, n);
            end else begin
               send_fmt_chunk(TAG_PCM, MONO, BITS_8, p_rate, $urandom_range(0, 5));
            end
         end else if (pick < 65) begin
            id = $urandom;
            if (id == ID_FMT || id == ID_DATA) begin
               id[31] = ~id[31];
            end
            send_body_chunk(id, $urandom_range(0, 9));
         end else if (pick < 82) begin
            send_fmt_chunk(TAG_PCM, MONO, BITS_8, p_rate, $urandom_range(0, 5));
         end else if (pick < 94) begin
            // One field of the fmt chunk is wrong; data must wait for a good one.
            tag   = TAG_PCM;
            chans = MONO;
            bits  = BITS_8;
            rate  = p_rate;
            case ($urandom_range(0, 4))
               0: tag   = ($urandom_range(0, 1) == 0) ? 16'h0101 : 16'h0000;
               1: chans = 16'($urandom_range(2, 65535));
               2: bits  = ($urandom_range(0, 1) == 0) ? 16'd16 : 16'h0808;
               3: rate  = p_rate ^ (32'd1 << $urandom_range(0, 31));
               default: tag = 16'($urandom_range(2, 65535));
            endcase
            send_fmt_chunk(tag, chans, bits, rate, $urandom_range(0, 5));
         end else begin
            case ($urandom_range(0, 3))
               0: rate = 32'd0;
               1: rate = 32'hFFFF_FFFF;
               2: rate = RATE_RESET;
               default: rate = $urandom;
            endcase
            write_rate(rate);
         end
      end
      no_gaps = 1'b0;
   endtask

   // Ends the stream in one of the ways that can still be reached, picked
   // at random, then checks that later transfers cause nothing.
   task automatic test_end_of_stream();
      if (!format_accepted()) begin
         send_fmt_chunk(TAG_PCM, MONO, BITS_8, p_rate, 0);
      end
      case ($urandom_range(0, 7))
         0: begin
            // End between chunks.
         end
         1: begin
            // End partway through a chunk header.
            repeat ($urandom_range(1, 7)) send_byte(8'($urandom), 1'b0);
         end
         2: begin
            send_chunk_header(ID_DATA, 32'd10);
            repeat (3) send_byte(8'($urandom), 1'b0);
         end
         3: begin
            send_chunk_header(ID_LIST, 32'd6);
            repeat (2) send_byte(8'($urandom), 1'b0);
         end
         4: begin
            send_chunk_header(ID_FMT, FMT_LEN);
            repeat (5) send_byte(8'($urandom), 1'b0);
         end
         5: begin
            // The end mark lands where the pad byte belongs.
            send_chunk_header(ID_DATA, 32'd1);
            send_byte(8'($urandom), 1'b0);
         end
         6: begin
            send_chunk_header(ID_FMT, $urandom_range(0, 15));
         end
         default: begin
            send_fmt_chunk(TAG_PCM, 16'd2, BITS_8, p_rate, 0);
            send_chunk_header(ID_DATA, 32'd4);
         end
      endcase
      // The byte that rides with the end mark is meaningless.
      send_byte(8'($urandom), 1'b1);
      repeat (8) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_file_header();
      test_first_format();
      test_sample_extremes();
      test_rate_register();
      test_format_replaced();
      test_input_backpressure();
      test_random_chunks();
      test_end_of_stream();

      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d input transfers in %0d chunks, %0d samples, %0d rate writes.",
               items_sent, chunks_sent, samples_seen, rate_writes);
      $display("The stream closed with event kind %0d and error code %0d.",
               last_kind, last_code);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
